// ===== src/rv32i_dec_pkg.sv =====
// Shared types and constants for the RV32I instruction decoder.
// Holds opcodes, format and mnemonic codes and the decoded result record.
// No dependencies.
package rv32i_dec_pkg;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 64;

    typedef enum logic [2:0] {
        FMT_INVALID = 3'd0,
        FMT_R       = 3'd1,
        FMT_I       = 3'd2,
        FMT_S       = 3'd3,
        FMT_B       = 3'd4,
        FMT_U       = 3'd5,
        FMT_J       = 3'd6,
        FMT_FENCE   = 3'd7
    } t_fmt;

    typedef enum logic [5:0] {
        MN_NONE   = 6'd0,
        MN_ADD    = 6'd1,  MN_SUB   = 6'd2,  MN_SLL   = 6'd3,  MN_SLT   = 6'd4,
        MN_SLTU   = 6'd5,  MN_XOR   = 6'd6,  MN_SRL   = 6'd7,  MN_SRA   = 6'd8,
        MN_OR     = 6'd9,  MN_AND   = 6'd10, MN_JALR  = 6'd11, MN_LB    = 6'd12,
        MN_LH     = 6'd13, MN_LW    = 6'd14, MN_LBU   = 6'd15, MN_LHU   = 6'd16,
        MN_ADDI   = 6'd17, MN_SLTI  = 6'd18, MN_SLTIU = 6'd19, MN_XORI  = 6'd20,
        MN_ORI    = 6'd21, MN_ANDI  = 6'd22, MN_SLLI  = 6'd23, MN_SRLI  = 6'd24,
        MN_SRAI   = 6'd25, MN_ECALL = 6'd26, MN_EBRK  = 6'd27, MN_SB    = 6'd28,
        MN_SH     = 6'd29, MN_SW    = 6'd30, MN_BEQ   = 6'd31, MN_BNE   = 6'd32,
        MN_BLT    = 6'd33, MN_BGE   = 6'd34, MN_BLTU  = 6'd35, MN_BGEU  = 6'd36,
        MN_LUI    = 6'd37, MN_AUIPC = 6'd38, MN_JAL   = 6'd39, MN_FENCE = 6'd40
    } t_mnem;

    typedef struct packed {
        t_fmt               fmt;
        logic [6:0]         opc;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic [2:0]         f3;
        logic [6:0]         f7;
        logic signed [20:0] imm;
        t_mnem              mnem;
    } t_dec_result;

endpackage

// ===== src/rv32i_dec_core.sv =====
// Combinational field split, immediate build and mnemonic lookup for one
// RV32I word. Depends on rv32i_dec_pkg.
module rv32i_dec_core
    import rv32i_dec_pkg::*;
(
    input  logic [31:0] i_instr,
    output t_dec_result o_result
);

    logic [6:0]  w_opc;
    logic [4:0]  w_rd;
    logic [2:0]  w_f3;
    logic [4:0]  w_rs1;
    logic [4:0]  w_rs2;
    logic [6:0]  w_f7;
    logic [11:0] w_imm_i;

    assign w_opc   = i_instr[6:0];
    assign w_rd    = i_instr[11:7];
    assign w_f3    = i_instr[14:12];
    assign w_rs1   = i_instr[19:15];
    assign w_rs2   = i_instr[24:20];
    assign w_f7    = i_instr[31:25];
    assign w_imm_i = i_instr[31:20];

    always_comb begin
        o_result      = '0;
        o_result.fmt  = FMT_INVALID;
        o_result.mnem = MN_NONE;
        o_result.opc  = w_opc;
        unique case (w_opc)
            OPC_LUI, OPC_AUIPC: begin
                o_result.fmt  = FMT_U;
                o_result.rd   = w_rd;
                o_result.imm  = {i_instr[31], i_instr[31:12]};
                o_result.mnem = (w_opc == OPC_LUI) ? MN_LUI : MN_AUIPC;
            end
            OPC_JAL: begin
                o_result.fmt  = FMT_J;
                o_result.rd   = w_rd;
                o_result.imm  = {i_instr[31], i_instr[19:12], i_instr[20],
                                 i_instr[30:21], 1'b0};
                o_result.mnem = MN_JAL;
            end
            OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_SYSTEM: begin
                o_result.fmt = FMT_I;
                o_result.rd  = w_rd;
                o_result.rs1 = w_rs1;
                o_result.f3  = w_f3;
                o_result.imm = {{9{i_instr[31]}}, w_imm_i};
                if (w_opc == OPC_JALR) begin
                    o_result.mnem = (w_f3 == 3'd0) ? MN_JALR : MN_NONE;
                end else if (w_opc == OPC_LOAD) begin
                    unique case (w_f3)
                        3'd0:    o_result.mnem = MN_LB;
                        3'd1:    o_result.mnem = MN_LH;
                        3'd2:    o_result.mnem = MN_LW;
                        3'd4:    o_result.mnem = MN_LBU;
                        3'd5:    o_result.mnem = MN_LHU;
                        default: o_result.mnem = MN_NONE;
                    endcase
                end else if (w_opc == OPC_OPIMM) begin
                    // shifts carry their funct7 in imm[11:5]
                    unique case (w_f3)
                        3'd0: o_result.mnem = MN_ADDI;
                        3'd1: o_result.mnem = (w_f7 == F7_ZERO) ? MN_SLLI : MN_NONE;
                        3'd2: o_result.mnem = MN_SLTI;
                        3'd3: o_result.mnem = MN_SLTIU;
                        3'd4: o_result.mnem = MN_XORI;
                        3'd5: o_result.mnem = (w_f7 == F7_ZERO) ? MN_SRLI :
                                              (w_f7 == F7_ALT)  ? MN_SRAI : MN_NONE;
                        3'd6: o_result.mnem = MN_ORI;
                        3'd7: o_result.mnem = MN_ANDI;
                    endcase
                end else if (w_f3 == 3'd0 && w_rd == 5'd0 && w_rs1 == 5'd0) begin
                    o_result.mnem = (w_imm_i == 12'd0) ? MN_ECALL :
                                    (w_imm_i == 12'd1) ? MN_EBRK  : MN_NONE;
                end
            end
            OPC_BRANCH: begin
                o_result.fmt = FMT_B;
                o_result.rs1 = w_rs1;
                o_result.rs2 = w_rs2;
                o_result.f3  = w_f3;
                o_result.imm = {{8{i_instr[31]}}, i_instr[31], i_instr[7],
                                i_instr[30:25], i_instr[11:8], 1'b0};
                unique case (w_f3)
                    3'd0:    o_result.mnem = MN_BEQ;
                    3'd1:    o_result.mnem = MN_BNE;
                    3'd4:    o_result.mnem = MN_BLT;
                    3'd5:    o_result.mnem = MN_BGE;
                    3'd6:    o_result.mnem = MN_BLTU;
                    3'd7:    o_result.mnem = MN_BGEU;
                    default: o_result.mnem = MN_NONE;
                endcase
            end
            OPC_STORE: begin
                o_result.fmt = FMT_S;
                o_result.rs1 = w_rs1;
                o_result.rs2 = w_rs2;
                o_result.f3  = w_f3;
                o_result.imm = {{9{i_instr[31]}}, w_f7, w_rd};
                unique case (w_f3)
                    3'd0:    o_result.mnem = MN_SB;
                    3'd1:    o_result.mnem = MN_SH;
                    3'd2:    o_result.mnem = MN_SW;
                    default: o_result.mnem = MN_NONE;
                endcase
            end
            OPC_OP: begin
                o_result.fmt = FMT_R;
                o_result.rd  = w_rd;
                o_result.rs1 = w_rs1;
                o_result.rs2 = w_rs2;
                o_result.f3  = w_f3;
                o_result.f7  = w_f7;
                if (w_f7 == F7_ZERO) begin
                    unique case (w_f3)
                        3'd0: o_result.mnem = MN_ADD;
                        3'd1: o_result.mnem = MN_SLL;
                        3'd2: o_result.mnem = MN_SLT;
                        3'd3: o_result.mnem = MN_SLTU;
                        3'd4: o_result.mnem = MN_XOR;
                        3'd5: o_result.mnem = MN_SRL;
                        3'd6: o_result.mnem = MN_OR;
                        3'd7: o_result.mnem = MN_AND;
                    endcase
                end else if (w_f7 == F7_ALT && w_f3 == 3'd0) begin
                    o_result.mnem = MN_SUB;
                end else if (w_f7 == F7_ALT && w_f3 == 3'd5) begin
                    o_result.mnem = MN_SRA;
                end
            end
            OPC_FENCE: begin
                o_result.fmt  = FMT_FENCE;
                o_result.f3   = w_f3;
                o_result.mnem = (w_f3 == 3'd0) ? MN_FENCE : MN_NONE;
            end
            default: begin
                // unknown opcode: only the opcode field is passed on
                o_result.fmt = FMT_INVALID;
            end
        endcase
    end

endmodule

// ===== src/rv32i_instruction_decoder.sv =====
// RV32I instruction decoder top level: input register, decode core and
// output register with stream handshakes. Depends on rv32i_dec_pkg and
// rv32i_dec_core.
//
// Usage:
//   Slave channel (i_s_*) takes one 32-bit instruction word per transaction.
//   Master channel (o_m_*) returns one decoded record per transaction.
//   A transaction completes on a rising edge with tvalid and tready high.
//   A word accepted on an edge is held in the input register, decoded
//   combinationally and captured into the output register, from which it
//   shows on the master side. The path is input register, decode logic,
//   output register, so one word is taken every cycle while the receiver
//   does not stall; throughput is one per clock under that condition.
//   Each register stage advances when it is empty or the stage after it
//   drains, so the slave side keeps accepting while a result waits.
//   When the receiver stalls, the output record holds and the input stage
//   fills; tready drops only once both stages are occupied.
//   Reset (i_rst_n low, synchronous) drops both stage valids; data held in
//   the stages is discarded and no transaction is in flight afterward.
module rv32i_instruction_decoder
    import rv32i_dec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [31:0] instruction_word
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [2:0] format_class, [9:3] opcode_bits, [14:10] dest_reg,
    // [19:15] src_reg_one, [24:20] src_reg_two, [27:25] minor_func,
    // [34:28] major_func, [55:35] immediate, [61:56] mnemonic_code, [63:62] 0
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic        r_in_vld;
    logic        n_in_vld;
    logic [31:0] r_in_word;
    logic        r_out_vld;
    logic        n_out_vld;
    t_dec_result r_out_res;
    t_dec_result w_dec_res;
    logic        w_out_ready;
    logic        w_in_ready;

    rv32i_dec_core u_core (
        .i_instr  (r_in_word),
        .o_result (w_dec_res)
    );

    assign w_out_ready = !r_out_vld || i_m_tready;
    assign w_in_ready  = !r_in_vld || w_out_ready;

    always_comb begin
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        if (w_in_ready) begin
            n_in_vld = i_s_tvalid;
        end
        if (w_out_ready) begin
            n_out_vld = r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_s_tvalid) begin
            r_in_word <= i_s_tdata;
        end
        if (w_out_ready && r_in_vld) begin
            r_out_res <= w_dec_res;
        end
    end

    assign o_s_tready = w_in_ready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_res.mnem, r_out_res.imm, r_out_res.f7,
                         r_out_res.f3, r_out_res.rs2, r_out_res.rs1,
                         r_out_res.rd, r_out_res.opc, r_out_res.fmt};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for rv32i_instruction_decoder: directed table, then random words.
// Keeps its own RV32I field decoder and checks every returned record in order.
// Depends on rv32i_dec_pkg and rv32i_instruction_decoder.
`timescale 1ns / 100ps

module testbench;
    import rv32i_dec_pkg::*;

    localparam int RAND_PER_PHASE = 175;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 8;

    localparam logic [2:0]  F3_BASE    = 3'd0;
    localparam logic [2:0]  F3_SHL     = 3'd1;
    localparam logic [2:0]  F3_SHR     = 3'd5;
    localparam logic [11:0] IMM_ECALL  = 12'd0;
    localparam logic [11:0] IMM_EBREAK = 12'd1;

    // Same bit order as o_m_tdata[61:0]; first member is the top field.
    typedef struct packed {
        t_mnem              mnem;
        logic signed [20:0] imm;
        logic [6:0]         f7;
        logic [2:0]         f3;
        logic [4:0]         rs2;
        logic [4:0]         rs1;
        logic [4:0]         rd;
        logic [6:0]         opc;
        t_fmt               fmt;
    } t_decoded_word;

    typedef struct {
        logic [31:0]   word;
        bit            typed;
        t_decoded_word rec;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    t_decoded_word pending_decodes [$];
    int            fail_count;
    int            src_idle_pct;
    int            sink_stall_pct;

    rv32i_instruction_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Mnemonic picked by funct3 alone; funct7, shift and SYSTEM rules come later.
    function automatic t_mnem funct3_mnemonic(input logic [6:0] opc, input logic [2:0] f3);
        t_mnem m;
        m = MN_NONE;
        case (opc)
            OPC_OP: begin
                case (f3)
                    3'd0: m = MN_ADD;
                    3'd1: m = MN_SLL;
                    3'd2: m = MN_SLT;
                    3'd3: m = MN_SLTU;
                    3'd4: m = MN_XOR;
                    3'd5: m = MN_SRL;
                    3'd6: m = MN_OR;
                    default: m = MN_AND;
                endcase
            end
            OPC_OPIMM: begin
                case (f3)
                    3'd0: m = MN_ADDI;
                    3'd1: m = MN_SLLI;
                    3'd2: m = MN_SLTI;
                    3'd3: m = MN_SLTIU;
                    3'd4: m = MN_XORI;
                    3'd5: m = MN_SRLI;
                    3'd6: m = MN_ORI;
                    default: m = MN_ANDI;
                endcase
            end
            OPC_LOAD: begin
                case (f3)
                    3'd0: m = MN_LB;
                    3'd1: m = MN_LH;
                    3'd2: m = MN_LW;
                    3'd4: m = MN_LBU;
                    3'd5: m = MN_LHU;
                    default: m = MN_NONE;
                endcase
            end
            OPC_STORE: begin
                case (f3)
                    3'd0: m = MN_SB;
                    3'd1: m = MN_SH;
                    3'd2: m = MN_SW;
                    default: m = MN_NONE;
                endcase
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0: m = MN_BEQ;
                    3'd1: m = MN_BNE;
                    3'd4: m = MN_BLT;
                    3'd5: m = MN_BGE;
                    3'd6: m = MN_BLTU;
                    3'd7: m = MN_BGEU;
                    default: m = MN_NONE;
                endcase
            end
            OPC_JALR:  m = (f3 == F3_BASE) ? MN_JALR : MN_NONE;
            OPC_FENCE: m = (f3 == F3_BASE) ? MN_FENCE : MN_NONE;
            default:   m = MN_NONE;
        endcase
        return m;
    endfunction

    function automatic t_decoded_word predict_record(input logic [31:0] w);
        t_decoded_word r;
        logic [6:0]    opc;
        logic [2:0]    f3;
        logic [11:0]   imm_i;
        opc   = w[6:0];
        f3    = w[14:12];
        imm_i = w[31:20];
        r     = '0;
        r.opc = opc;
        case (opc)
            OPC_LUI, OPC_AUIPC: begin
                r.fmt  = FMT_U;
                r.rd   = w[11:7];
                r.imm  = {w[31], w[31:12]};
                r.mnem = (opc == OPC_LUI) ? MN_LUI : MN_AUIPC;
            end
            OPC_JAL: begin
                r.fmt  = FMT_J;
                r.rd   = w[11:7];
                r.imm  = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                r.mnem = MN_JAL;
            end
            OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_SYSTEM: begin
                r.fmt  = FMT_I;
                r.rd   = w[11:7];
                r.rs1  = w[19:15];
                r.f3   = f3;
                r.imm  = {{9{w[31]}}, imm_i};
                r.mnem = funct3_mnemonic(opc, f3);
                if (opc == OPC_OPIMM && f3 == F3_SHL && imm_i[11:5] != F7_ZERO)
                    r.mnem = MN_NONE;
                if (opc == OPC_OPIMM && f3 == F3_SHR)
                    r.mnem = (imm_i[11:5] == F7_ZERO) ? MN_SRLI :
                             (imm_i[11:5] == F7_ALT)  ? MN_SRAI : MN_NONE;
                if (opc == OPC_SYSTEM && f3 == F3_BASE && w[11:7] == 5'd0 && w[19:15] == 5'd0)
                    r.mnem = (imm_i == IMM_ECALL)  ? MN_ECALL :
                             (imm_i == IMM_EBREAK) ? MN_EBRK  : MN_NONE;
            end
            OPC_BRANCH: begin
                r.fmt  = FMT_B;
                r.rs1  = w[19:15];
                r.rs2  = w[24:20];
                r.f3   = f3;
                r.imm  = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                r.mnem = funct3_mnemonic(opc, f3);
            end
            OPC_STORE: begin
                r.fmt  = FMT_S;
                r.rs1  = w[19:15];
                r.rs2  = w[24:20];
                r.f3   = f3;
                r.imm  = {{9{w[31]}}, w[31:25], w[11:7]};
                r.mnem = funct3_mnemonic(opc, f3);
            end
            OPC_OP: begin
                r.fmt = FMT_R;
                r.rd  = w[11:7];
                r.rs1 = w[19:15];
                r.rs2 = w[24:20];
                r.f3  = f3;
                r.f7  = w[31:25];
                if (w[31:25] == F7_ZERO)
                    r.mnem = funct3_mnemonic(opc, f3);
                else if (w[31:25] == F7_ALT && f3 == F3_BASE)
                    r.mnem = MN_SUB;
                else if (w[31:25] == F7_ALT && f3 == F3_SHR)
                    r.mnem = MN_SRA;
                else
                    r.mnem = MN_NONE;
            end
            OPC_FENCE: begin
                r.fmt  = FMT_FENCE;
                r.f3   = f3;
                r.mnem = funct3_mnemonic(opc, f3);
            end
            default: r.fmt = FMT_INVALID;
        endcase
        return r;
    endfunction

    function automatic t_decoded_word known_record(input t_fmt f, input logic [6:0] opc,
                                                   input t_mnem m);
        t_decoded_word r;
        r      = '0;
        r.fmt  = f;
        r.opc  = opc;
        r.mnem = m;
        return r;
    endfunction

    // Mostly real encodings with random operands; the rest is raw noise.
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 99) < 12)
            return w;
        case ($urandom_range(0, 10))
            0:       w[6:0] = OPC_LUI;
            1:       w[6:0] = OPC_AUIPC;
            2:       w[6:0] = OPC_JAL;
            3:       w[6:0] = OPC_JALR;
            4:       w[6:0] = OPC_LOAD;
            5:       w[6:0] = OPC_OPIMM;
            6:       w[6:0] = OPC_SYSTEM;
            7:       w[6:0] = OPC_BRANCH;
            8:       w[6:0] = OPC_STORE;
            9:       w[6:0] = OPC_OP;
            default: w[6:0] = OPC_FENCE;
        endcase
        if ($urandom_range(0, 3) == 0)
            return w;
        if (w[6:0] == OPC_SYSTEM) begin
            w[31:7] = {11'd0, 1'($urandom_range(0, 1)), 13'd0};
        end else if (w[6:0] != OPC_LUI && w[6:0] != OPC_AUIPC && w[6:0] != OPC_JAL) begin
            // redraw funct3 until it names an instruction
            while (funct3_mnemonic(w[6:0], w[14:12]) == MN_NONE)
                w[14:12] = 3'($urandom_range(0, 7));
            if (w[6:0] == OPC_OP)
                w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
            if (w[6:0] == OPC_OPIMM && w[14:12] == F3_SHL)
                w[31:25] = F7_ZERO;
            if (w[6:0] == OPC_OPIMM && w[14:12] == F3_SHR)
                w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
        end
        return w;
    endfunction

    function automatic string record_text(input t_decoded_word r);
        return $sformatf("fmt %0d opc %h rd %0d rs1 %0d rs2 %0d f3 %0d f7 %h imm %0d mnem %0d",
                         r.fmt, r.opc, r.rd, r.rs1, r.rs2, r.f3, r.f7, r.imm, r.mnem);
    endfunction

    task automatic log_fault(input string what);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, what);
        fail_count++;
    endtask

    // Drive one word at the falling edge, hold until the transaction completes.
    task automatic send_word(input logic [31:0] w, input bit typed, input t_decoded_word rec);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        do @(posedge i_clk); while (!o_s_tready);
        pending_decodes.push_back(typed ? rec : predict_record(w));
    endtask

    // Hold tready low during reset, then stall at the phase's rate.
    always @(negedge i_clk) begin
        i_m_tready <= i_rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_decoded_word got;
        t_decoded_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_decoded_word'(o_m_tdata[61:0]);
            if (pending_decodes.size() == 0) begin
                log_fault({"unexpected record: ", record_text(got)});
            end else begin
                want = pending_decodes.pop_front();
                if (got.fmt !== want.fmt || got.opc !== want.opc || got.rd !== want.rd ||
                    got.rs1 !== want.rs1 || got.rs2 !== want.rs2 || got.f3 !== want.f3 ||
                    got.f7 !== want.f7 || got.imm !== want.imm || got.mnem !== want.mnem)
                    log_fault({"mismatch\n  expected ", record_text(want),
                               "\n  actual   ", record_text(got)});
            end
        end
    end

    initial begin
        #5_000_000;
        $display("rv32i_instruction_decoder verification failed");
        $finish;
    end

    initial begin
        t_dir_row dir_tab [$];
        int       guard;
        fail_count     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;

        dir_tab = '{
            '{32'h0000_0000, 1'b1, known_record(FMT_INVALID, 7'h00, MN_NONE)},
            '{32'hFFFF_FFFF, 1'b1, known_record(FMT_INVALID, 7'h7F, MN_NONE)},
            '{32'hFFFF_FF7B, 1'b1, known_record(FMT_INVALID, 7'h7B, MN_NONE)},
            '{32'h0000_000F, 1'b1, known_record(FMT_FENCE, OPC_FENCE, MN_FENCE)},
            '{32'h0000_100F, 1'b0, '0},   // fence with nonzero funct3
            '{32'h01FF_8FB3, 1'b0, '0},   // add, all registers 31
            '{32'h4031_00B3, 1'b0, '0},   // sub
            '{32'h4031_50B3, 1'b0, '0},   // sra
            '{32'h0231_00B3, 1'b0, '0},   // extension funct7
            '{32'h4000_1093, 1'b0, '0},   // slli with high immediate bits set
            '{32'h41F0_D093, 1'b0, '0},   // srai
            '{32'hFFF0_D093, 1'b0, '0},   // right shift, bad upper immediate
            '{32'hFFF1_3093, 1'b0, '0},   // sltiu -1
            '{32'h8000_0013, 1'b0, '0},   // addi most negative
            '{32'h7FF0_0013, 1'b0, '0},   // addi most positive
            '{32'h0000_1067, 1'b0, '0},   // jalr bad funct3
            '{32'h0000_80E7, 1'b0, '0},   // jalr
            '{32'h0000_3003, 1'b0, '0},   // load unused funct3
            '{32'h0000_3023, 1'b0, '0},   // store unused funct3
            '{32'h0000_2063, 1'b0, '0},   // branch unused funct3
            '{32'hFE00_7FE3, 1'b0, '0},   // bgeu, offset -2
            '{32'h0000_0073, 1'b0, '0},   // ecall
            '{32'h0010_0073, 1'b0, '0},   // ebreak
            '{32'h0020_0073, 1'b0, '0},   // system, other immediate
            '{32'hFFFF_F0B7, 1'b0, '0},   // lui all ones
            '{32'h7FFF_F097, 1'b0, '0},   // auipc most positive
            '{32'h8000_006F, 1'b0, '0},   // jal most negative
            '{32'h7FFF_F0EF, 1'b0, '0}    // jal most positive
        };

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k])
            send_word(dir_tab[k].word, dir_tab[k].typed, dir_tab[k].rec);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            repeat (RAND_PER_PHASE)
                send_word(random_instruction(), 1'b0, '0);
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        guard = 0;
        while (pending_decodes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_decodes.size() != 0)
            log_fault($sformatf("%0d records never returned", pending_decodes.size()));

        if (fail_count == 0)
            $display("rv32i_instruction_decoder verification clean");
        else
            $display("rv32i_instruction_decoder verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rv32i_dec_pkg.sv
src/rv32i_dec_core.sv
src/rv32i_instruction_decoder.sv
dv/testbench.sv
